FILE: hw/rtl/gcmc_pkg.sv
`default_nettype none

package gcmc_pkg;

    // Command codes
    localparam logic [3:0] OP_MOVE      = 4'd0;
    localparam logic [3:0] OP_RETRACT   = 4'd1;
    localparam logic [3:0] OP_UNRETRACT = 4'd2;
    localparam logic [3:0] OP_ABS       = 4'd3;
    localparam logic [3:0] OP_REL       = 4'd4;
    localparam logic [3:0] OP_SETPOS    = 4'd5;
    localparam logic [3:0] OP_E_ABS     = 4'd6;
    localparam logic [3:0] OP_E_REL     = 4'd7;
    localparam logic [3:0] OP_TOOL      = 4'd8;
    localparam logic [3:0] OP_ROLE      = 4'd9;
    localparam logic [3:0] OP_VOLUME    = 4'd10;
    localparam logic [3:0] OP_WIDTH     = 4'd11;
    localparam logic [3:0] OP_HEIGHT    = 4'd12;

    // Move types
    localparam logic [2:0] MT_TRAVEL    = 3'd0;
    localparam logic [2:0] MT_RETRACT   = 3'd1;
    localparam logic [2:0] MT_UNRETRACT = 3'd2;
    localparam logic [2:0] MT_EXTRUDE   = 3'd3;
    localparam logic [2:0] MT_TOOL      = 3'd4;

    // Axis indexes and presence bits
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;
    localparam int AXIS_E = 3;
    localparam int AXIS_COUNT = 4;
    localparam int PRESENT_F = 4;

    // Bounds of the extrusion roles that print: from FIRST_PRINT up to, not including, MIXED
    localparam logic [3:0] ROLE_FIRST_PRINT = 4'd1;
    localparam logic [3:0] ROLE_MIXED       = 4'd12;

    // Reciprocals: x/5 = (x * SCALE_RECIP) >> 34, y/15 = (y * FEED_RECIP) >> 35
    localparam logic [31:0] SCALE_RECIP = 32'hCCCC_CCCD;
    localparam logic [31:0] FEED_RECIP  = 32'h8888_8889;
    localparam logic [31:0] FEED_ROUND  = 32'd30;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]         op;
        logic [4:0]         axis_present;
        logic signed [31:0] x_word;
        logic signed [31:0] y_word;
        logic signed [31:0] z_word;
        logic signed [31:0] e_word;
        logic [30:0]        f_word;
        logic signed [31:0] argument;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         motion_kind;
        logic               beat_last;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] extrude_delta;
        logic [30:0]        feed_rate;
        logic [7:0]         tool_number;
        logic [3:0]         role_code;
        logic signed [31:0] line_width;
        logic signed [31:0] line_height;
        logic signed [31:0] volume_per_length;
    } beat_t;

    // Inch scaling of a remainder r in 0..4: floor((254*r + 5) / 10)
    function automatic logic [6:0] scale_frac(input logic [2:0] rem);
        logic [6:0] val;
        unique case (rem)
            3'd0:    val = 7'd0;
            3'd1:    val = 7'd25;
            3'd2:    val = 7'd51;
            3'd3:    val = 7'd76;
            3'd4:    val = 7'd102;
            default: val = 7'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gcode_move_classifier_unit.sv
// A stored move passes registered stages A, B and C into the output buffer, which
// shows its start beat, then its end beat once the start beat has transferred.
// Throughput: one command per cycle when it stores nothing and nothing stalls; a
// stored move holds the single output buffer until its two beats have transferred.
// Reset (rst_n, async, active low) clears positions, modes, tags, feed, tool,
// inch mode and all pipeline and output valid bits.
`default_nettype none

module gcode_move_classifier_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic            cfg_wr_data,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire gcmc_pkg::cmd_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output gcmc_pkg::beat_t      out_data
);

    // Pipeline control
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic in_xfer, out_xfer;
    logic adv_b, adv_c, exec_fire;
    logic a_ready, b_ready, c_ready, ob_free;

    gcmc_pkg::cmd_t a_cmd_reg, b_cmd_reg, c_cmd_reg;
    logic [31:0]    feed_sum;
    logic [63:0]    feed_prod;
    logic [28:0]    b_feed_reg, c_feed_reg;

    logic signed [31:0] a_words [gcmc_pkg::AXIS_COUNT];
    logic signed [31:0] scaled  [gcmc_pkg::AXIS_COUNT];

    // Architectural state
    logic               inch_reg;
    logic signed [31:0] pos_reg  [gcmc_pkg::AXIS_COUNT];
    logic signed [31:0] pos_next [gcmc_pkg::AXIS_COUNT];
    logic [30:0]        feed_reg, feed_next;
    logic signed [31:0] width_reg, width_next;
    logic signed [31:0] height_reg, height_next;
    logic signed [31:0] volume_reg, volume_next;
    logic [3:0]         role_reg, role_next;
    logic [7:0]         tool_reg, tool_next;
    logic               grel_reg, grel_next;
    logic               erel_reg, erel_next;

    // Move evaluation
    logic signed [31:0] mv_pos [gcmc_pkg::AXIS_COUNT];
    logic               mv_dxy, mv_dxyz, extrude_ok;
    logic               mv_store;
    logic [2:0]         mv_type;
    logic               exec_store;
    logic [2:0]         exec_type;
    logic [32:0]        delta_wide;
    logic [31:0]        delta_sat;

    // Output buffer
    logic               ob_valid_reg, ob_beat_reg;
    logic [2:0]         ob_type_reg;
    logic signed [31:0] ob_start_reg [3];
    logic signed [31:0] ob_end_reg   [3];
    logic signed [31:0] ob_delta_reg;
    logic [30:0]        ob_feed_reg;
    logic [7:0]         ob_tool_reg;
    logic [3:0]         ob_role_reg;
    logic signed [31:0] ob_width_reg, ob_height_reg, ob_volume_reg;

    // Handshake and stage advance
    assign out_xfer  = ob_valid_reg && !out_stall;
    assign ob_free   = !ob_valid_reg || (ob_beat_reg && !out_stall);
    assign exec_fire = c_valid_reg && (!exec_store || ob_free);
    assign c_ready   = !c_valid_reg || exec_fire;
    assign adv_c     = b_valid_reg && c_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign adv_b     = a_valid_reg && b_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_stall  = !a_ready;
    assign in_xfer   = in_valid && a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_xfer || (a_valid_reg && !adv_b);
            b_valid_reg <= adv_b || (b_valid_reg && !adv_c);
            c_valid_reg <= adv_c || (c_valid_reg && !exec_fire);
        end
    end

    // Feed conversion: (f + 30) / 60 as ((f + 30) >> 2) / 15
    assign feed_sum  = {1'b0, a_cmd_reg.f_word} + gcmc_pkg::FEED_ROUND;
    assign feed_prod = {34'b0, feed_sum[31:2]} * {32'b0, gcmc_pkg::FEED_RECIP};

    // Command payload stages
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            a_cmd_reg <= in_data;
        if (adv_b)
        begin
            b_cmd_reg  <= a_cmd_reg;
            b_feed_reg <= feed_prod[63:35];
        end
        if (adv_c)
        begin
            c_cmd_reg  <= b_cmd_reg;
            c_feed_reg <= b_feed_reg;
        end
    end

    assign a_words[gcmc_pkg::AXIS_X] = a_cmd_reg.x_word;
    assign a_words[gcmc_pkg::AXIS_Y] = a_cmd_reg.y_word;
    assign a_words[gcmc_pkg::AXIS_Z] = a_cmd_reg.z_word;
    assign a_words[gcmc_pkg::AXIS_E] = a_cmd_reg.e_word;

    // One scaler per axis word, aligned with stage C
    for (genvar g = 0; g < gcmc_pkg::AXIS_COUNT; g++)
    begin : g_scale
        gcmc_len_scale u_scale (
            .clk    (clk),
            .load_b (adv_b),
            .load_c (adv_c),
            .inch   (inch_reg),
            .word   (a_words[g]),
            .scaled (scaled[g])
        );
    end

    // Per-axis target of a linear move, saturating in relative mode
    for (genvar g = 0; g < gcmc_pkg::AXIS_COUNT; g++)
    begin : g_axis
        logic        rel;
        logic [32:0] sum;
        logic [31:0] sum_sat;

        assign rel = grel_reg || ((g == gcmc_pkg::AXIS_E) && erel_reg);
        assign sum = {pos_reg[g][31], pos_reg[g]} + {scaled[g][31], scaled[g]};
        assign sum_sat = (sum[32] != sum[31])
                       ? (sum[32] ? gcmc_pkg::SAT_MIN : gcmc_pkg::SAT_MAX)
                       : sum[31:0];
        assign mv_pos[g] = !c_cmd_reg.axis_present[g] ? pos_reg[g]
                         : (rel ? sum_sat : scaled[g]);
    end

    // Classify the move
    assign mv_dxy  = (mv_pos[gcmc_pkg::AXIS_X] != pos_reg[gcmc_pkg::AXIS_X])
                  || (mv_pos[gcmc_pkg::AXIS_Y] != pos_reg[gcmc_pkg::AXIS_Y]);
    assign mv_dxyz = mv_dxy
                  || (mv_pos[gcmc_pkg::AXIS_Z] != pos_reg[gcmc_pkg::AXIS_Z]);
    assign extrude_ok = (width_reg != 32'sd0) && (height_reg != 32'sd0)
                     && (role_reg >= gcmc_pkg::ROLE_FIRST_PRINT)
                     && (role_reg < gcmc_pkg::ROLE_MIXED);

    always_comb
    begin
        mv_store = 1'b1;
        mv_type  = gcmc_pkg::MT_TRAVEL;
        priority if (mv_pos[gcmc_pkg::AXIS_E] < pos_reg[gcmc_pkg::AXIS_E])
        begin
            mv_type = mv_dxyz ? gcmc_pkg::MT_TRAVEL : gcmc_pkg::MT_RETRACT;
        end
        else if (mv_pos[gcmc_pkg::AXIS_E] > pos_reg[gcmc_pkg::AXIS_E])
        begin
            if (!mv_dxyz)
                mv_type = gcmc_pkg::MT_UNRETRACT;
            else if (mv_dxy)
                mv_type = extrude_ok ? gcmc_pkg::MT_EXTRUDE : gcmc_pkg::MT_TRAVEL;
            else
                mv_store = 1'b0;
        end
        else
        begin
            mv_store = mv_dxyz;
        end
    end

    // Execute one command against the state
    always_comb
    begin
        pos_next    = pos_reg;
        feed_next   = feed_reg;
        width_next  = width_reg;
        height_next = height_reg;
        volume_next = volume_reg;
        role_next   = role_reg;
        tool_next   = tool_reg;
        grel_next   = grel_reg;
        erel_next   = erel_reg;
        exec_store  = 1'b0;
        exec_type   = gcmc_pkg::MT_TRAVEL;
        unique case (c_cmd_reg.op)
            gcmc_pkg::OP_MOVE:
            begin
                pos_next   = mv_pos;
                exec_store = mv_store;
                exec_type  = mv_type;
                if (c_cmd_reg.axis_present[gcmc_pkg::PRESENT_F])
                    feed_next = {2'b0, c_feed_reg};
            end
            gcmc_pkg::OP_RETRACT:
            begin
                exec_store = 1'b1;
                exec_type  = gcmc_pkg::MT_RETRACT;
            end
            gcmc_pkg::OP_UNRETRACT:
            begin
                exec_store = 1'b1;
                exec_type  = gcmc_pkg::MT_UNRETRACT;
            end
            gcmc_pkg::OP_ABS:   grel_next = 1'b0;
            gcmc_pkg::OP_REL:   grel_next = 1'b1;
            gcmc_pkg::OP_SETPOS:
            begin
                for (int i = 0; i < gcmc_pkg::AXIS_COUNT; i++)
                begin
                    if (c_cmd_reg.axis_present[3:0] == 4'b0)
                        pos_next[i] = 32'sd0;
                    else if (c_cmd_reg.axis_present[i])
                        pos_next[i] = scaled[i];
                end
            end
            gcmc_pkg::OP_E_ABS: erel_next = 1'b0;
            gcmc_pkg::OP_E_REL: erel_next = 1'b1;
            gcmc_pkg::OP_TOOL:
            begin
                tool_next = c_cmd_reg.argument[7:0];
                if (c_cmd_reg.argument[7:0] != tool_reg)
                begin
                    exec_store = 1'b1;
                    exec_type  = gcmc_pkg::MT_TOOL;
                end
            end
            gcmc_pkg::OP_ROLE:
            begin
                if (!c_cmd_reg.argument[31]
                    && (c_cmd_reg.argument[30:0] <= {27'b0, gcmc_pkg::ROLE_MIXED}))
                    role_next = c_cmd_reg.argument[3:0];
            end
            gcmc_pkg::OP_VOLUME: volume_next = c_cmd_reg.argument;
            gcmc_pkg::OP_WIDTH:  width_next  = c_cmd_reg.argument;
            gcmc_pkg::OP_HEIGHT: height_next = c_cmd_reg.argument;
            default: ;
        endcase
    end

    // Extrude delta against the E position at command start
    assign delta_wide = {pos_next[gcmc_pkg::AXIS_E][31], pos_next[gcmc_pkg::AXIS_E]}
                      - {pos_reg[gcmc_pkg::AXIS_E][31], pos_reg[gcmc_pkg::AXIS_E]};
    assign delta_sat  = (delta_wide[32] != delta_wide[31])
                      ? (delta_wide[32] ? gcmc_pkg::SAT_MIN : gcmc_pkg::SAT_MAX)
                      : delta_wide[31:0];

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inch_reg <= 1'b0;
        else if (cfg_wr_en)
            inch_reg <= cfg_wr_data;
    end

    // Commit state when a command executes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gcmc_pkg::AXIS_COUNT; i++)
                pos_reg[i] <= 32'sd0;
            feed_reg   <= 31'd0;
            width_reg  <= 32'sd0;
            height_reg <= 32'sd0;
            volume_reg <= 32'sd0;
            role_reg   <= 4'd0;
            tool_reg   <= 8'd0;
            grel_reg   <= 1'b0;
            erel_reg   <= 1'b0;
        end
        else if (exec_fire)
        begin
            pos_reg    <= pos_next;
            feed_reg   <= feed_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            volume_reg <= volume_next;
            role_reg   <= role_next;
            tool_reg   <= tool_next;
            grel_reg   <= grel_next;
            erel_reg   <= erel_next;
        end
    end

    // Output buffer control: load a stored move, then step start beat to end beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
            ob_beat_reg  <= 1'b0;
        end
        else if (exec_fire && exec_store)
        begin
            ob_valid_reg <= 1'b1;
            ob_beat_reg  <= 1'b0;
        end
        else if (out_xfer && ob_beat_reg)
        begin
            ob_valid_reg <= 1'b0;
        end
        else if (out_xfer)
        begin
            ob_beat_reg <= 1'b1;
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (exec_fire && exec_store)
        begin
            ob_type_reg <= exec_type;
            for (int i = 0; i < 3; i++)
            begin
                ob_start_reg[i] <= pos_reg[i];
                ob_end_reg[i]   <= pos_next[i];
            end
            ob_delta_reg  <= delta_sat;
            ob_feed_reg   <= feed_next;
            ob_tool_reg   <= tool_next;
            ob_role_reg   <= role_reg;
            ob_width_reg  <= width_reg;
            ob_height_reg <= height_reg;
            ob_volume_reg <= volume_reg;
        end
    end

    // Present the current beat
    assign out_valid = ob_valid_reg;

    always_comb
    begin
        out_data.motion_kind       = ob_type_reg;
        out_data.beat_last         = ob_beat_reg;
        out_data.point_x           = ob_beat_reg ? ob_end_reg[0] : ob_start_reg[0];
        out_data.point_y           = ob_beat_reg ? ob_end_reg[1] : ob_start_reg[1];
        out_data.point_z           = ob_beat_reg ? ob_end_reg[2] : ob_start_reg[2];
        out_data.extrude_delta     = ob_delta_reg;
        out_data.feed_rate         = ob_feed_reg;
        out_data.tool_number       = ob_tool_reg;
        out_data.role_code         = ob_role_reg;
        out_data.line_width        = ob_width_reg;
        out_data.line_height       = ob_height_reg;
        out_data.volume_per_length = ob_volume_reg;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gcmc_len_scale.sv
`default_nettype none

// Two-stage inch-to-millimeter scaler: word*25.4, rounded half away from zero,
// saturated to 32-bit signed. Passes the word through when inch mode is off.
module gcmc_len_scale (
    input  wire logic               clk,
    input  wire logic               load_b,
    input  wire logic               load_c,
    input  wire logic               inch,
    input  wire logic signed [31:0] word,
    output logic signed [31:0]      scaled
);

    logic [31:0]        mag;
    logic [63:0]        prod;
    logic               neg_b_reg;
    logic [2:0]         mag_b_reg;
    logic [28:0]        quo_b_reg;
    logic signed [31:0] word_b_reg;
    logic [2:0]         rem;
    logic [35:0]        q_mag;
    logic [31:0]        sat_val;
    logic signed [31:0] scaled_c_reg;

    // Split magnitude into quotient and remainder by 5
    assign mag  = word[31] ? (~word + 32'd1) : word;
    assign prod = {32'b0, mag} * {32'b0, gcmc_pkg::SCALE_RECIP};

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            neg_b_reg  <= word[31];
            mag_b_reg  <= mag[2:0];
            quo_b_reg  <= prod[62:34];
            word_b_reg <= word;
        end
    end

    // 254*(5p + r)/10 = 127p + frac(r); only the low bits of mag - 5p are needed
    assign rem   = mag_b_reg - (quo_b_reg[2:0] + {quo_b_reg[0], 2'b00});
    assign q_mag = {quo_b_reg, 7'b0} - {7'b0, quo_b_reg}
                 + {29'b0, gcmc_pkg::scale_frac(rem)};

    // Restore sign and saturate
    always_comb
    begin
        if (!neg_b_reg)
            sat_val = (q_mag > {4'b0, gcmc_pkg::SAT_MAX}) ? gcmc_pkg::SAT_MAX
                                                          : q_mag[31:0];
        else
            sat_val = (q_mag > {4'b0, gcmc_pkg::SAT_MIN}) ? gcmc_pkg::SAT_MIN
                                                          : (~q_mag[31:0] + 32'd1);
    end

    always_ff @(posedge clk)
    begin
        if (load_c)
            scaled_c_reg <= inch ? sat_val : word_b_reg;
    end

    assign scaled = scaled_c_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/gcmc_checker.sv
`default_nettype none

module gcmc_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            out_valid,
    input wire logic            out_stall,
    input wire gcmc_pkg::beat_t out_data
);

    // Hold a stalled beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    // End beat follows a start beat transfer, with the same move type
    a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.beat_last
        |=> out_valid && out_data.beat_last
            && (out_data.motion_kind == $past(out_data.motion_kind)))
        else $error("start beat not followed by matching end beat");

    // After an end beat transfer, the next beat shown is a start beat
    a_start_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.beat_last
        |=> !out_valid || !out_data.beat_last)
        else $error("end beat repeated");

    // Tool changes never move the extruder
    a_tool_delta: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.motion_kind == gcmc_pkg::MT_TOOL)
        |-> out_data.extrude_delta == 32'sd0)
        else $error("tool change with extrude delta");

endmodule

bind gcode_move_classifier_unit gcmc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

FILE: tb/sv/gcode_move_classifier_unit_tb.sv
`timescale 1ns / 1ps

module gcode_move_classifier_unit_tb;

    // Command codes and a move type with no name in the package
    localparam logic [3:0] OP_OTHER = 4'd13;
    localparam logic [3:0] OP_LAST  = 4'd15;
    localparam logic [2:0] MT_NONE  = 3'd7;

    // Presence bits of one command
    localparam logic [4:0] HAS_X = 5'(1 << gcmc_pkg::AXIS_X);
    localparam logic [4:0] HAS_Y = 5'(1 << gcmc_pkg::AXIS_Y);
    localparam logic [4:0] HAS_Z = 5'(1 << gcmc_pkg::AXIS_Z);
    localparam logic [4:0] HAS_E = 5'(1 << gcmc_pkg::AXIS_E);
    localparam logic [4:0] HAS_F = 5'(1 << gcmc_pkg::PRESENT_F);
    localparam logic [4:0] HAS_XYZE = HAS_X | HAS_Y | HAS_Z | HAS_E;

    localparam longint INCH_NUM     = 254;
    localparam longint INCH_DEN     = 10;
    localparam longint FEED_PER_MIN = 60;

    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_PRINTED   = 100;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_wr_en = 1'b0;
    logic            cfg_wr_data = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    gcmc_pkg::cmd_t  in_data = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    gcmc_pkg::beat_t out_data;

    // Commands waiting to be offered and beats waiting to be seen
    gcmc_pkg::cmd_t  pending_cmds[$];
    gcmc_pkg::beat_t expected_beats[$];
    gcmc_pkg::beat_t next_beat;

    int offered_count = 0;
    int taken_count = 0;
    int beat_count = 0;
    int mismatch_count = 0;
    int beat_tally[8];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_done = 0;
    int hold_left = 0;

    // Predicted machine state
    logic signed [31:0] axis_pos[gcmc_pkg::AXIS_COUNT];
    logic signed [31:0] line_start[3];
    logic signed [31:0] line_start_e;
    logic [30:0]        feed_mm_s;
    logic signed [31:0] cur_width;
    logic signed [31:0] cur_height;
    logic signed [31:0] volume_tag;
    logic [3:0]         role_tag;
    logic [7:0]         tool_id;
    logic               rel_all;
    logic               rel_e;
    logic               inch_mode;

    gcode_move_classifier_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    always #4 clk = ~clk;

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > 64'sd2147483647)
            return gcmc_pkg::SAT_MAX;
        if (v < -64'sd2147483648)
            return gcmc_pkg::SAT_MIN;
        return v[31:0];
    endfunction

    // Convert a length word to mm, rounding half away from zero
    function automatic logic signed [31:0] to_mm(input logic signed [31:0] w);
        longint n;
        n = longint'(w) * INCH_NUM;
        if (!inch_mode)
            return w;
        if (n >= 0)
            return sat32((n + INCH_DEN / 2) / INCH_DEN);
        return sat32(-((-n + INCH_DEN / 2) / INCH_DEN));
    endfunction

    function automatic gcmc_pkg::beat_t make_beat(input logic [2:0] kind, input logic last,
                                                  input logic signed [31:0] px,
                                                  input logic signed [31:0] py,
                                                  input logic signed [31:0] pz);
        gcmc_pkg::beat_t b;
        b.motion_kind       = kind;
        b.beat_last         = last;
        b.point_x           = px;
        b.point_y           = py;
        b.point_z           = pz;
        b.extrude_delta     = sat32(longint'(axis_pos[gcmc_pkg::AXIS_E])
                                    - longint'(line_start_e));
        b.feed_rate         = feed_mm_s;
        b.tool_number       = tool_id;
        b.role_code         = role_tag;
        b.line_width        = cur_width;
        b.line_height       = cur_height;
        b.volume_per_length = volume_tag;
        return b;
    endfunction

    // Advance the predicted state by one command and queue the beats it stores
    task automatic classify_command(input gcmc_pkg::cmd_t c);
        logic signed [31:0] words[gcmc_pkg::AXIS_COUNT];
        logic signed [31:0] next_pos[gcmc_pkg::AXIS_COUNT];
        logic signed [31:0] v;
        logic [2:0]         kind;
        logic               rel;
        logic               moved_xy;
        logic               moved_xyz;
        longint             arg;
        int                 a;
        gcmc_pkg::beat_t    nb;
        kind = MT_NONE;
        arg = longint'($signed(c.argument));
        words[gcmc_pkg::AXIS_X] = c.x_word;
        words[gcmc_pkg::AXIS_Y] = c.y_word;
        words[gcmc_pkg::AXIS_Z] = c.z_word;
        words[gcmc_pkg::AXIS_E] = c.e_word;

        // Tags leave the line start alone
        if (c.op >= gcmc_pkg::OP_ROLE && c.op <= gcmc_pkg::OP_HEIGHT)
        begin
            case (c.op)
                gcmc_pkg::OP_ROLE:
                begin
                    if (arg >= 0 && arg <= longint'(gcmc_pkg::ROLE_MIXED))
                        role_tag = arg[3:0];
                end
                gcmc_pkg::OP_VOLUME: volume_tag = c.argument;
                gcmc_pkg::OP_WIDTH:  cur_width = c.argument;
                default:             cur_height = c.argument;
            endcase
            return;
        end

        for (a = 0; a < 3; a++)
            line_start[a] = axis_pos[a];
        line_start_e = axis_pos[gcmc_pkg::AXIS_E];

        case (c.op)
            gcmc_pkg::OP_MOVE:
            begin
                for (a = 0; a < gcmc_pkg::AXIS_COUNT; a++)
                begin
                    rel = rel_all || (a == gcmc_pkg::AXIS_E && rel_e);
                    if (c.axis_present[a])
                    begin
                        v = to_mm(words[a]);
                        next_pos[a] = rel ? sat32(longint'(axis_pos[a]) + longint'(v)) : v;
                    end
                    else
                        next_pos[a] = axis_pos[a];
                end
                if (c.axis_present[gcmc_pkg::PRESENT_F])
                    feed_mm_s = 31'((longint'(c.f_word) + FEED_PER_MIN / 2) / FEED_PER_MIN);
                moved_xy = next_pos[gcmc_pkg::AXIS_X] != axis_pos[gcmc_pkg::AXIS_X] ||
                           next_pos[gcmc_pkg::AXIS_Y] != axis_pos[gcmc_pkg::AXIS_Y];
                moved_xyz = moved_xy ||
                            next_pos[gcmc_pkg::AXIS_Z] != axis_pos[gcmc_pkg::AXIS_Z];
                if (next_pos[gcmc_pkg::AXIS_E] < axis_pos[gcmc_pkg::AXIS_E])
                    kind = moved_xyz ? gcmc_pkg::MT_TRAVEL : gcmc_pkg::MT_RETRACT;
                else if (next_pos[gcmc_pkg::AXIS_E] > axis_pos[gcmc_pkg::AXIS_E])
                begin
                    if (!moved_xyz)
                        kind = gcmc_pkg::MT_UNRETRACT;
                    else if (moved_xy)
                        kind = gcmc_pkg::MT_EXTRUDE;
                end
                else if (moved_xyz)
                    kind = gcmc_pkg::MT_TRAVEL;
                // Extrusion without a printable role or a line size is a travel
                if (kind == gcmc_pkg::MT_EXTRUDE &&
                    (cur_width == 0 || cur_height == 0 ||
                     role_tag < gcmc_pkg::ROLE_FIRST_PRINT ||
                     role_tag >= gcmc_pkg::ROLE_MIXED))
                    kind = gcmc_pkg::MT_TRAVEL;
                for (a = 0; a < gcmc_pkg::AXIS_COUNT; a++)
                    axis_pos[a] = next_pos[a];
            end
            gcmc_pkg::OP_RETRACT:   kind = gcmc_pkg::MT_RETRACT;
            gcmc_pkg::OP_UNRETRACT: kind = gcmc_pkg::MT_UNRETRACT;
            gcmc_pkg::OP_ABS:       rel_all = 1'b0;
            gcmc_pkg::OP_REL:       rel_all = 1'b1;
            gcmc_pkg::OP_SETPOS:
            begin
                for (a = 0; a < gcmc_pkg::AXIS_COUNT; a++)
                begin
                    if (c.axis_present[3:0] == '0)
                        axis_pos[a] = '0;
                    else if (c.axis_present[a])
                        axis_pos[a] = to_mm(words[a]);
                end
            end
            gcmc_pkg::OP_E_ABS:     rel_e = 1'b0;
            gcmc_pkg::OP_E_REL:     rel_e = 1'b1;
            gcmc_pkg::OP_TOOL:
            begin
                if (c.argument[7:0] != tool_id)
                begin
                    tool_id = c.argument[7:0];
                    kind = gcmc_pkg::MT_TOOL;
                end
            end
            default:                kind = MT_NONE;
        endcase

        if (kind != MT_NONE)
        begin
            nb = make_beat(kind, 1'b0, line_start[gcmc_pkg::AXIS_X],
                           line_start[gcmc_pkg::AXIS_Y], line_start[gcmc_pkg::AXIS_Z]);
            expected_beats.insert(expected_beats.size(), nb);
            nb = make_beat(kind, 1'b1, axis_pos[gcmc_pkg::AXIS_X],
                           axis_pos[gcmc_pkg::AXIS_Y], axis_pos[gcmc_pkg::AXIS_Z]);
            expected_beats.insert(expected_beats.size(), nb);
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("ERROR %0t ns: beat %0d: %s", $time, beat_count, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    // Sample configuration writes and command transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                inch_mode = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                classify_command(in_data);
                taken_count++;
            end
        end
    end

    // Check each beat transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("beat arrived with nothing predicted");
            else
            begin
                next_beat = expected_beats.pop_front();
                check_field("motion_kind", 32'(out_data.motion_kind),
                            32'(next_beat.motion_kind));
                check_field("beat_last", 32'(out_data.beat_last), 32'(next_beat.beat_last));
                check_field("point_x", out_data.point_x, next_beat.point_x);
                check_field("point_y", out_data.point_y, next_beat.point_y);
                check_field("point_z", out_data.point_z, next_beat.point_z);
                check_field("extrude_delta", out_data.extrude_delta,
                            next_beat.extrude_delta);
                check_field("feed_rate", 32'(out_data.feed_rate), 32'(next_beat.feed_rate));
                check_field("tool_number", 32'(out_data.tool_number),
                            32'(next_beat.tool_number));
                check_field("role_code", 32'(out_data.role_code), 32'(next_beat.role_code));
                check_field("line_width", out_data.line_width, next_beat.line_width);
                check_field("line_height", out_data.line_height, next_beat.line_height);
                check_field("volume_per_length", out_data.volume_per_length,
                            next_beat.volume_per_length);
                beat_tally[next_beat.motion_kind]++;
            end
            beat_count++;
        end
    end

    // Offer commands; hold a command until it transfers
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || taken_count == offered_count)
        begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data <= pending_cmds.pop_front();
                in_valid <= 1'b1;
                offered_count++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the output at random, or for a long stretch when asked
    always @(negedge clk)
    begin
        if (hold_done != hold_asked)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = hold_asked;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic signed [31:0] mm(input int v);
        return 32'(v) <<< 16;
    endfunction

    task automatic queue_cmd(input logic [3:0] op, input logic [4:0] present,
                             input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input logic signed [31:0] e,
                             input logic [30:0] f, input logic signed [31:0] arg);
        gcmc_pkg::cmd_t c;
        c.op           = op;
        c.axis_present = present;
        c.x_word       = x;
        c.y_word       = y;
        c.z_word       = z;
        c.e_word       = e;
        c.f_word       = f;
        c.argument     = arg;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // Mostly short lengths, some zeros, full-range words and the extremes
    function automatic logic signed [31:0] random_len();
        int unsigned pick;
        logic [31:0] r;
        pick = $urandom_range(99);
        r = $urandom_range(32'h00C8_0000);
        if (pick < 70)
            return $signed(r - 32'h0064_0000);
        if (pick < 80)
            return '0;
        if (pick < 92)
            return $urandom;
        case ($urandom_range(3))
            0:       return gcmc_pkg::SAT_MAX;
            1:       return gcmc_pkg::SAT_MIN;
            2:       return 32'sd1;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic gcmc_pkg::cmd_t random_cmd();
        gcmc_pkg::cmd_t c;
        int unsigned pick;
        pick = $urandom_range(99);
        c.axis_present = 5'($urandom_range(31));
        c.x_word = random_len();
        c.y_word = random_len();
        c.z_word = random_len();
        c.e_word = random_len();
        c.f_word = ($urandom_range(99) < 80) ? 31'($urandom_range(32'h0100_0000))
                                             : 31'($urandom);
        c.argument = $urandom;
        if (pick < 55)
            c.op = gcmc_pkg::OP_MOVE;
        else if (pick < 60)
            c.op = gcmc_pkg::OP_RETRACT;
        else if (pick < 64)
            c.op = gcmc_pkg::OP_UNRETRACT;
        else if (pick < 67)
            c.op = gcmc_pkg::OP_ABS;
        else if (pick < 70)
            c.op = gcmc_pkg::OP_REL;
        else if (pick < 74)
        begin
            c.op = gcmc_pkg::OP_SETPOS;
            if ($urandom_range(3) == 0)
                c.axis_present[3:0] = '0;
        end
        else if (pick < 76)
            c.op = gcmc_pkg::OP_E_ABS;
        else if (pick < 78)
            c.op = gcmc_pkg::OP_E_REL;
        else if (pick < 83)
        begin
            c.op = gcmc_pkg::OP_TOOL;
            if ($urandom_range(9) < 8)
                c.argument = 32'($urandom_range(3));
        end
        else if (pick < 87)
        begin
            c.op = gcmc_pkg::OP_ROLE;
            if ($urandom_range(9) < 9)
                c.argument = 32'($urandom_range(15));
        end
        else if (pick < 95)
        begin
            c.op = (pick < 89) ? gcmc_pkg::OP_VOLUME
                 : (pick < 92) ? gcmc_pkg::OP_WIDTH : gcmc_pkg::OP_HEIGHT;
            if ($urandom_range(9) < 8)
                c.argument = 32'($urandom_range(32'h0002_0000, 32'h0000_1000));
            else if ($urandom_range(1) == 0)
                c.argument = '0;
        end
        else
            c.op = 4'($urandom_range(OP_OTHER, OP_LAST));
        return c;
    endfunction

    task automatic queue_random(input int count);
        int i;
        for (i = 0; i < count; i++)
            pending_cmds.insert(pending_cmds.size(), random_cmd());
    endtask

    // Wait until every command has transferred and every beat has arrived
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || taken_count != offered_count ||
               expected_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_units(input logic inch);
        @(negedge clk);
        cfg_wr_data <= inch;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int a;
        for (a = 0; a < gcmc_pkg::AXIS_COUNT; a++)
            axis_pos[a] = '0;
        for (a = 0; a < 3; a++)
            line_start[a] = '0;
        for (a = 0; a < 8; a++)
            beat_tally[a] = 0;
        line_start_e = '0;
        feed_mm_s = '0;
        cur_width = '0;
        cur_height = '0;
        volume_tag = '0;
        role_tag = '0;
        tool_id = '0;
        rel_all = 1'b0;
        rel_e = 1'b0;
        inch_mode = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Millimeter units, sender idles less than receiver
        write_units(1'b0);
        send_idle_pct = 38;
        recv_idle_pct = 65;
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_X | HAS_Y | HAS_F, mm(10), mm(5), 0, 0,
                  31'h7FFF_FFFF, 0);
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_E, 0, 0, 0, mm(1), 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_X | HAS_E, mm(12), 0, 0, mm(2), 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_ROLE, 5'd0, 0, 0, 0, 0, 31'd0,
                  32'(gcmc_pkg::ROLE_FIRST_PRINT));
        queue_cmd(gcmc_pkg::OP_WIDTH, 5'd0, 0, 0, 0, 0, 31'd0, 32'h0000_6666);
        queue_cmd(gcmc_pkg::OP_HEIGHT, 5'd0, 0, 0, 0, 0, 31'd0, 32'h0000_3333);
        queue_cmd(gcmc_pkg::OP_VOLUME, 5'd0, 0, 0, 0, 0, 31'd0, gcmc_pkg::SAT_MIN);
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_X | HAS_E | HAS_F, mm(20), 0, 0, mm(3), 31'd1, 0);
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_E, 0, 0, 0, mm(2), 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_Z | HAS_E, 0, 0, 32'h0000_3333, mm(4), 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_MOVE, 5'd0, 0, 0, 0, 0, 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_X | HAS_E, mm(30), 0, 0, mm(1), 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_ROLE, 5'd0, 0, 0, 0, 0, 31'd0,
                  32'(gcmc_pkg::ROLE_MIXED) + 1);
        queue_cmd(gcmc_pkg::OP_ROLE, 5'd0, 0, 0, 0, 0, 31'd0, -32'sd1);
        queue_cmd(gcmc_pkg::OP_ROLE, 5'd0, 0, 0, 0, 0, 31'd0, 32'(gcmc_pkg::ROLE_MIXED));
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_Y | HAS_E, 0, mm(9), 0, mm(5), 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_RETRACT, 5'd0, 0, 0, 0, 0, 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_UNRETRACT, 5'd0, 0, 0, 0, 0, 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_TOOL, 5'd0, 0, 0, 0, 0, 31'd0, 32'h0000_00FF);
        queue_cmd(gcmc_pkg::OP_TOOL, 5'd0, 0, 0, 0, 0, 31'd0, 32'h7FFF_FFFF);
        queue_cmd(gcmc_pkg::OP_REL, 5'd0, 0, 0, 0, 0, 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_XYZE | HAS_F, gcmc_pkg::SAT_MAX, gcmc_pkg::SAT_MIN,
                  gcmc_pkg::SAT_MAX, gcmc_pkg::SAT_MAX, 31'h7FFF_FFFF, 0);
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_XYZE, gcmc_pkg::SAT_MAX, gcmc_pkg::SAT_MIN,
                  gcmc_pkg::SAT_MAX, gcmc_pkg::SAT_MAX, 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_ABS, 5'd0, 0, 0, 0, 0, 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_E_REL, 5'd0, 0, 0, 0, 0, 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_SETPOS, HAS_X | HAS_E, mm(-7), 0, 0, mm(-3), 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_X | HAS_E, mm(-6), 0, 0, mm(1), 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_E_ABS, 5'd0, 0, 0, 0, 0, 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_SETPOS, HAS_F, mm(1), mm(1), mm(1), mm(1), 31'd5, 0);
        queue_cmd(OP_OTHER, HAS_XYZE | HAS_F, mm(1), mm(1), mm(1), mm(1), 31'd5, 0);
        queue_cmd(OP_LAST, 5'd0, 0, 0, 0, 0, 31'd0, 0);
        queue_random(350);
        wait_idle();

        // Inch units, receiver idles less than sender; drain halfway through
        write_units(1'b1);
        send_idle_pct = 65;
        recv_idle_pct = 38;
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_X | HAS_Y | HAS_Z, 32'sd1, -32'sd1, 32'sd3, 0,
                  31'd0, 0);
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_X | HAS_Y | HAS_E, gcmc_pkg::SAT_MAX,
                  gcmc_pkg::SAT_MIN, 0, mm(2), 31'd0, 0);
        queue_cmd(gcmc_pkg::OP_SETPOS, HAS_Y | HAS_Z | HAS_E, 0, mm(-1), 32'sd5, mm(3),
                  31'd0, 0);
        queue_cmd(gcmc_pkg::OP_WIDTH, 5'd0, 0, 0, 0, 0, 31'd0, mm(1));
        queue_cmd(gcmc_pkg::OP_MOVE, HAS_X | HAS_E, mm(1), 0, 0, gcmc_pkg::SAT_MIN, 31'd0, 0);
        queue_random(175);
        wait_idle();
        queue_random(175);
        wait_idle();

        // Millimeter units at full rate, then a long output stall
        write_units(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(150);
        wait_idle();
        queue_random(150);
        hold_asked++;
        wait_idle();

        $display("Covered %0d commands in mm and inch units under idle, stall and drain",
                 taken_count);
        $display("Checked %0d beats: travel %0d, retract %0d, unretract %0d, extrude %0d, %s",
                 beat_count, beat_tally[gcmc_pkg::MT_TRAVEL],
                 beat_tally[gcmc_pkg::MT_RETRACT], beat_tally[gcmc_pkg::MT_UNRETRACT],
                 beat_tally[gcmc_pkg::MT_EXTRUDE],
                 $sformatf("tool %0d", beat_tally[gcmc_pkg::MT_TOOL]));
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #4_000_000;
        $display("ERROR: run did not finish, %0d beats still predicted", expected_beats.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
